/* src/lht_pkg.sv */
// lht_pkg: shared types, constants and codes of the lru handle table
// depends on nothing; used by the interfaces, the cell and the top level
package lht_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // wide enough for the 4-bit slot field and for any slot number
  localparam int EXT_W  = (SLOT_W > 4) ? SLOT_W : 4;

  localparam int NAME_FRONT_W = 64;
  localparam int NAME_BACK_W  = 24;
  localparam int DRIVE_W      = 8;

  localparam logic [NAME_FRONT_W-1:0] BLANK_FRONT = 64'h2020_2020_2020_2020;
  localparam logic [NAME_BACK_W-1:0]  BLANK_BACK  = 24'h20_2020;

  typedef logic [SLOT_W-1:0] slot_id_t;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_TOUCH  = 2'd1,
    ACT_CLOSE  = 2'd2
  } action_t;

  typedef struct packed {
    logic [DRIVE_W-1:0]      drive;
    logic [NAME_FRONT_W-1:0] name_front;
    logic [NAME_BACK_W-1:0]  name_back;
  } key_t;

  typedef struct packed {
    slot_id_t id;
    key_t     key;
  } entry_t;

  // per-cell control from the top level
  typedef struct packed {
    logic shift;   // take the entry from the left neighbor
    logic blank;   // set the name to spaces, keep the drive
  } cell_ctl_t;

endpackage

/* src/lht_if.sv */
// lht_req_if / lht_rsp_if: valid-ready channels of the lru handle table
// depends on lht_pkg for field widths
interface lht_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           action;
  logic [3:0]                           slot;
  logic [lht_pkg::DRIVE_W-1:0]          drive;
  logic [lht_pkg::NAME_FRONT_W-1:0]     name_front;
  logic [lht_pkg::NAME_BACK_W-1:0]      name_back;

  modport source (output valid, action, slot, drive, name_front, name_back, input ready);
  modport sink   (input valid, action, slot, drive, name_front, name_back, output ready);
endinterface

interface lht_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] found_slot;
  logic       hit;

  modport source (output valid, found_slot, hit, input ready);
  modport sink   (input valid, found_slot, hit, output ready);
endinterface

/* src/lht_cell.sv */
// lht_cell: one recency position of the table, holding a slot number and its key
// depends on lht_pkg
module lht_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  lht_pkg::slot_id_t   rst_id,
  input  lht_pkg::cell_ctl_t  ctl,
  input  lht_pkg::entry_t     left_in,
  input  lht_pkg::key_t       req_key,
  input  lht_pkg::slot_id_t   touch_id,
  output lht_pkg::entry_t     entry_q,
  output logic                key_match,
  output logic                id_match
);

  lht_pkg::entry_t entry_r;
  lht_pkg::entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift) begin
      entry_nxt = left_in;
    end else if (ctl.blank) begin
      entry_nxt.key.name_front = lht_pkg::BLANK_FRONT;
      entry_nxt.key.name_back  = lht_pkg::BLANK_BACK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.id             <= rst_id;
      entry_r.key.drive      <= '0;
      entry_r.key.name_front <= lht_pkg::BLANK_FRONT;
      entry_r.key.name_back  <= lht_pkg::BLANK_BACK;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry_q   = entry_r;
  assign key_match = (entry_r.key == req_key);
  assign id_match  = (entry_r.id == touch_id);

endmodule

/* src/lru_handle_table.sv */
// lru_handle_table: top level, a fully associative 16-slot handle table in recency order
// depends on lht_pkg, lht_req_if / lht_rsp_if and lht_cell
//
// usage
//   in_ch carries one request: action (lookup, touch, close), slot, drive and the
//   11-byte name split into name_front and name_back. out_ch returns one result per
//   request: found_slot and hit.
//   the table is a row of cells, one per recency position, front at cell 0. each
//   cell holds a slot number together with that slot's key, so a move to front is
//   a one-position shift of the cells ahead of the moved entry.
//   operation: a request is registered at acceptance; once the output register is
//   free or being taken, all cells compare the key in parallel, the nearest match
//   is picked and the shift is applied while the result is loaded into the output
//   register, which drives out_ch.
//   a new request is taken only after the previous one has completed, since the
//   single request register holds a request through its compare-and-reorder step.
//   stall: the output register holds its result until taken; a pending request
//   waits in the request register and in_ch.ready stays low until it completes.
//   reset (rst_n low, synchronous): all names blank, drives zero, position i holds
//   slot i, no request pending, no result valid.
module lru_handle_table (
  input  logic      clk,
  input  logic      rst_n,
  lht_req_if.sink   in_ch,
  lht_rsp_if.source out_ch
);

  localparam int S = lht_pkg::SLOTS;

  // request register
  logic                req_valid_r;
  logic [1:0]          req_action_r;
  logic [3:0]          req_slot_r;
  lht_pkg::key_t       req_key_r;

  // output register
  logic                out_valid_r;
  logic [3:0]          out_slot_r;
  logic                out_hit_r;
  logic [3:0]          out_slot_nxt;
  logic                out_hit_nxt;

  // cell row
  lht_pkg::entry_t     cell_q   [S];
  lht_pkg::entry_t     cell_in  [S];
  lht_pkg::cell_ctl_t  cell_ctl [S];
  logic [S-1:0]        key_match;
  logic [S-1:0]        id_match;

  logic                fire;
  logic                any_hit;
  lht_pkg::slot_id_t   hit_pos;
  lht_pkg::slot_id_t   touch_pos;
  logic [lht_pkg::EXT_W-1:0] slot_ext;
  lht_pkg::slot_id_t   touch_id;
  logic                touch_ok;

  logic                move_en;
  lht_pkg::slot_id_t   move_pos;
  logic                blank_en;
  lht_pkg::entry_t     front_entry;
  logic [S-1:0]        id_seen;

  function automatic logic [3:0] slot_field(input lht_pkg::slot_id_t id);
    logic [lht_pkg::EXT_W-1:0] e;
    e = lht_pkg::EXT_W'(id);
    return e[3:0];
  endfunction

  assign in_ch.ready = !req_valid_r;
  assign fire        = req_valid_r && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      req_valid_r <= 1'b1;
    end else if (fire) begin
      req_valid_r <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_action_r         <= in_ch.action;
      req_slot_r           <= in_ch.slot;
      req_key_r.drive      <= in_ch.drive;
      req_key_r.name_front <= in_ch.name_front;
      req_key_r.name_back  <= in_ch.name_back;
    end
  end

  // touch target: slots beyond the table leave the order alone
  assign slot_ext = lht_pkg::EXT_W'(req_slot_r);
  assign touch_id = slot_ext[lht_pkg::SLOT_W-1:0];
  assign touch_ok = {1'b0, slot_ext} < (lht_pkg::EXT_W + 1)'(S);

  // nearest-to-front match and touch position
  always_comb begin
    any_hit   = |key_match;
    hit_pos   = '0;
    touch_pos = '0;
    for (int p = S - 1; p >= 0; p--) begin
      if (key_match[p]) hit_pos   = lht_pkg::SLOT_W'(p);
      if (id_match[p])  touch_pos = lht_pkg::SLOT_W'(p);
    end
  end

  // decide the reorder and the result
  always_comb begin
    move_en      = 1'b0;
    move_pos     = lht_pkg::SLOT_W'(S - 1);
    blank_en     = 1'b0;
    out_slot_nxt = '0;
    out_hit_nxt  = 1'b0;
    front_entry  = cell_q[move_pos];
    case (req_action_r)
      lht_pkg::ACT_LOOKUP, lht_pkg::ACT_CLOSE: begin
        if (any_hit) begin
          // hit keeps the order; close blanks the hit slot in place
          out_slot_nxt = slot_field(cell_q[hit_pos].id);
          out_hit_nxt  = 1'b1;
          blank_en     = (req_action_r == lht_pkg::ACT_CLOSE);
        end else begin
          // miss: least recent slot takes the key and moves to the front
          move_en         = 1'b1;
          front_entry.key = req_key_r;
          if (req_action_r == lht_pkg::ACT_CLOSE) begin
            front_entry.key.name_front = lht_pkg::BLANK_FRONT;
            front_entry.key.name_back  = lht_pkg::BLANK_BACK;
          end
          out_slot_nxt = slot_field(cell_q[S-1].id);
        end
      end
      lht_pkg::ACT_TOUCH: begin
        move_en      = touch_ok;
        move_pos     = touch_pos;
        front_entry  = cell_q[touch_pos];
        out_slot_nxt = req_slot_r;
      end
      default: begin
        // undefined action: no change, zero result
      end
    endcase
  end

  // per-cell control and neighbor wiring
  always_comb begin
    for (int p = 0; p < S; p++) begin
      cell_ctl[p].shift = fire && move_en && (lht_pkg::SLOT_W'(p) <= move_pos);
      cell_ctl[p].blank = fire && blank_en && (lht_pkg::SLOT_W'(p) == hit_pos);
      cell_in[p]        = (p == 0) ? front_entry : cell_q[(p == 0) ? 0 : p - 1];
    end
  end

  for (genvar g = 0; g < S; g++) begin : g_cell
    lht_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .rst_id    (lht_pkg::SLOT_W'(g)),
      .ctl       (cell_ctl[g]),
      .left_in   (cell_in[g]),
      .req_key   (req_key_r),
      .touch_id  (touch_id),
      .entry_q   (cell_q[g]),
      .key_match (key_match[g]),
      .id_match  (id_match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_slot_r <= out_slot_nxt;
      out_hit_r  <= out_hit_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found_slot = out_slot_r;
  assign out_ch.hit        = out_hit_r;

  // slot numbers held by the row, for the permutation check
  always_comb begin
    id_seen = '0;
    for (int p = 0; p < S; p++) begin
      id_seen[cell_q[p].id] = 1'b1;
    end
  end

  // the row always holds every slot number exactly once
  a_perm: assert property (@(posedge clk) disable iff (!rst_n) &id_seen)
    else $error("recency row lost a slot number");

  // a completed request always leaves a result in the output register
  a_result: assert property (@(posedge clk) disable iff (!rst_n) fire |=> out_valid_r)
    else $error("request completed without a result");

  // a valid touch puts the named slot at the front
  a_touch: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && req_action_r == lht_pkg::ACT_TOUCH && touch_ok)
      |=> (cell_q[0].id == $past(touch_id)))
    else $error("touched slot not at the front");

  // a request is never accepted while another one is pending
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    (req_valid_r && !fire) |=> (req_valid_r && $stable(req_action_r)))
    else $error("pending request lost or overwritten");

endmodule

/* test/lht_checker.sv */
// lht_checker: watches the request and result channels of the lru handle table,
// keeps its own copy of the table, predicts every result and compares it
// depends on lht_pkg for the key layout, slot count and action codes
module lht_checker
  import lht_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              in_action,
  input  logic [3:0]              in_slot,
  input  logic [DRIVE_W-1:0]      in_drive,
  input  logic [NAME_FRONT_W-1:0] in_name_front,
  input  logic [NAME_BACK_W-1:0]  in_name_back,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [3:0]              out_found_slot,
  input  logic                    out_hit,
  input  logic                    drain_done,
  output int                      fail_count,
  output int                      pending,
  output int                      hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0] found_slot;
    logic       hit;
  } result_t;

  key_t     slot_key [SLOTS];
  slot_id_t recency  [SLOTS];
  result_t  expected_results [$];
  logic     leftover_checked;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_key[i] = '{drive: '0, name_front: BLANK_FRONT, name_back: BLANK_BACK};
      recency[i]  = slot_id_t'(i);
    end
  endtask

  // move the entry at recency position pos to the front
  task automatic promote(input int pos);
    slot_id_t s;
    if (pos == 0 || pos >= SLOTS) return;
    s = recency[pos];
    for (int i = pos; i > 0; i--) recency[i] = recency[i-1];
    recency[0] = s;
  endtask

  // front-to-back search, reuse the least recent slot on a miss
  task automatic find_or_claim(input key_t key, output slot_id_t s, output logic was_hit);
    was_hit = 1'b0;
    s = recency[SLOTS-1];
    for (int p = 0; p < SLOTS; p++) begin
      if (!was_hit && slot_key[recency[p]] == key) begin
        was_hit = 1'b1;
        s = recency[p];
      end
    end
    if (!was_hit) begin
      promote(SLOTS-1);
      slot_key[s] = key;
    end
  endtask

  task automatic predict_request(input logic [1:0] act, input logic [3:0] slot_field,
                                 input key_t key, output result_t res);
    slot_id_t s;
    logic     was_hit;
    logic     moved;
    res = '0;
    case (act)
      ACT_LOOKUP: begin
        find_or_claim(key, s, was_hit);
        res.found_slot = 4'(s);
        res.hit = was_hit;
      end
      ACT_TOUCH: begin
        res.found_slot = slot_field;
        if (int'(slot_field) < SLOTS) begin
          moved = 1'b0;
          for (int p = 0; p < SLOTS; p++) begin
            if (!moved && int'(recency[p]) == int'(slot_field)) begin
              promote(p);
              moved = 1'b1;
            end
          end
        end
      end
      ACT_CLOSE: begin
        find_or_claim(key, s, was_hit);
        slot_key[s].name_front = BLANK_FRONT;
        slot_key[s].name_back  = BLANK_BACK;
        res.found_slot = 4'(s);
        res.hit = was_hit;
      end
      default: res = '0;
    endcase
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t res;
    key_t    key;
    if (!rst_n) begin
      clear_table();
      expected_results.delete();
      leftover_checked = 1'b0;
    end else begin
      // results first: a result never belongs to a request taken at the same edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result slot %0d hit %0d with no request waiting",
                                    out_found_slot, out_hit));
        end else begin
          want = expected_results.pop_front();
          if (out_found_slot !== want.found_slot)
            report_mismatch($sformatf("found_slot %0d, expected %0d",
                                      out_found_slot, want.found_slot));
          if (out_hit !== want.hit)
            report_mismatch($sformatf("hit %0d, expected %0d", out_hit, want.hit));
          if (out_hit === 1'b1) hit_count++;
        end
      end
      if (in_valid && in_ready) begin
        key = '{drive: in_drive, name_front: in_name_front, name_back: in_name_back};
        predict_request(in_action, in_slot, key, res);
        expected_results.push_back(res);
      end
      if (drain_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (expected_results.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      end
    end
    pending = expected_results.size();
  end

endmodule

/* test/lru_handle_table_tb.sv */
// lru_handle_table_tb: stimulus and verdict for the lru handle table
// depends on lht_pkg, lht_req_if / lht_rsp_if, lru_handle_table and lht_checker
module lru_handle_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lht_pkg::*;

  // action code the block leaves undefined
  localparam logic [1:0] ACT_UNDEFINED = 2'd3;

  localparam int RANDOM_ITEMS     = 1230;
  localparam int CALM_ITEMS       = 150;   // tail of the run with no idling
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int POOL_SIZE        = 32;
  localparam int DRAIN_LIMIT      = 10000;

  logic clk;
  logic rst_n;

  lht_req_if req_ch ();
  lht_rsp_if rsp_ch ();

  int   fail_count;
  int   pending;
  int   hit_count;
  logic drain_done;

  // long_hold_pending and rx_calm are shared between the request and result processes
  logic long_hold_pending;
  logic tx_calm;
  logic rx_calm;
  logic tx_busy;
  int   sent_by_action [4];

  key_t name_pool [POOL_SIZE];

  lru_handle_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  lht_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (req_ch.valid),
    .in_ready       (req_ch.ready),
    .in_action      (req_ch.action),
    .in_slot        (req_ch.slot),
    .in_drive       (req_ch.drive),
    .in_name_front  (req_ch.name_front),
    .in_name_back   (req_ch.name_back),
    .out_valid      (rsp_ch.valid),
    .out_ready      (rsp_ch.ready),
    .out_found_slot (rsp_ch.found_slot),
    .out_hit        (rsp_ch.hit),
    .drain_done     (drain_done),
    .fail_count     (fail_count),
    .pending        (pending),
    .hit_count      (hit_count)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // safety net well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout: run did not finish");
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic key_t make_key(input logic [DRIVE_W-1:0] d,
                                    input logic [NAME_FRONT_W-1:0] f,
                                    input logic [NAME_BACK_W-1:0] b);
    return '{drive: d, name_front: f, name_back: b};
  endfunction

  // any key at all, every bit free
  function automatic key_t random_key();
    return make_key(8'($urandom_range(0, 255)), {$urandom, $urandom}, 24'($urandom));
  endfunction

  // a key worth reusing: mostly real drive numbers, sometimes a blank name
  function automatic key_t fresh_pool_key();
    key_t k;
    k = random_key();
    if ($urandom_range(0, 3) != 0) k.drive = 8'($urandom_range(0, 16));
    if ($urandom_range(0, 7) == 0) begin
      k.name_front = BLANK_FRONT;
      k.name_back  = BLANK_BACK;
    end
    return k;
  endfunction

  // offer one request and hold it until taken, then maybe go quiet for a burst
  task automatic send_request(input logic [1:0] act, input logic [3:0] slot_field,
                              input key_t key);
    req_ch.action     <= act;
    req_ch.slot       <= slot_field;
    req_ch.drive      <= key.drive;
    req_ch.name_front <= key.name_front;
    req_ch.name_back  <= key.name_back;
    req_ch.valid      <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    sent_by_action[act]++;
    if (!tx_calm && tx_busy && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every expected result is back
  task automatic wait_for_results();
    int guard;
    guard = 0;
    req_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < DRAIN_LIMIT);
  endtask

  // result side: random hold-off bursts, calm stretches, and one long hold
  initial begin : receiver
    int   stall_left;
    int   mode_left;
    logic rx_busy;
    stall_left = 0;
    mode_left  = 0;
    rx_busy    = 1'b0;
    rsp_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (mode_left == 0) begin
        mode_left = 64;
        rx_busy = ($urandom_range(0, 2) != 0);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
      end else if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        stall_left = LONG_HOLD_CYCLES;
      end else if (!rx_calm && rx_busy && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      rsp_ch.ready <= (stall_left == 0);
      @(posedge clk);
    end
  end

  // request side
  initial begin : stimulus
    key_t       blank0;
    key_t       ones;
    key_t       zeros;
    int         pick;
    int         pool_span;
    logic [3:0] slot_field;

    // every block input known from time zero
    rst_n             = 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.action     <= ACT_LOOKUP;
    req_ch.slot       <= '0;
    req_ch.drive      <= '0;
    req_ch.name_front <= '0;
    req_ch.name_back  <= '0;
    drain_done        = 1'b0;
    long_hold_pending = 1'b0;
    tx_calm           = 1'b0;
    rx_calm           = 1'b0;
    tx_busy           = 1'b1;
    pool_span         = POOL_SIZE - 1;
    for (int i = 0; i < 4; i++) sent_by_action[i] = 0;
    for (int i = 0; i < POOL_SIZE; i++) name_pool[i] = fresh_pool_key();

    blank0 = make_key('0, BLANK_FRONT, BLANK_BACK);
    ones   = make_key('1, '1, '1);
    zeros  = make_key('0, '0, '0);

    // hold reset, then release it
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    // every slot starts as drive 0 with a blank name, so the front one must win
    send_request(ACT_LOOKUP, 4'd0, blank0);
    send_request(ACT_LOOKUP, 4'd0, ones);      // miss, least recent slot reused
    send_request(ACT_LOOKUP, 4'd0, zeros);
    send_request(ACT_LOOKUP, 4'd0, ones);      // now a hit, no reorder
    send_request(ACT_TOUCH, 4'd0, zeros);
    send_request(ACT_TOUCH, 4'd0, ones);       // touching the front slot
    send_request(ACT_TOUCH, 4'd15, zeros);
    send_request(ACT_TOUCH, 4'd9, random_key());
    send_request(ACT_CLOSE, 4'd0, ones);       // close on a hit keeps drive 255
    send_request(ACT_LOOKUP, 4'd0, make_key(8'hff, BLANK_FRONT, BLANK_BACK));
    // close on a miss allocates then blanks
    send_request(ACT_CLOSE, 4'd3, make_key(8'd16, 64'h8000_0000_0000_0000, 24'h80_0000));
    send_request(ACT_LOOKUP, 4'd0, make_key(8'd16, BLANK_FRONT, BLANK_BACK));
    send_request(ACT_CLOSE, 4'd0, blank0);
    send_request(ACT_UNDEFINED, 4'd0, random_key());
    send_request(ACT_UNDEFINED, 4'd15, ones);
    send_request(ACT_LOOKUP, 4'd0, make_key(8'h80, 64'h0123_4567_89ab_cdef, 24'hfe_dcba));
    send_request(ACT_LOOKUP, 4'd0, make_key(8'd1, 64'h5555_5555_5555_5555, 24'haa_aaaa));
    send_request(ACT_TOUCH, 4'd1, ones);
    send_request(ACT_LOOKUP, 4'd0, blank0);
    send_request(ACT_CLOSE, 4'd0, zeros);

    // random part: mostly reused keys so hits, misses and closes interleave
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        pool_span = $urandom_range(8, POOL_SIZE - 1);
        tx_busy   = ($urandom_range(0, 2) != 0);
      end
      // receiver holds off while requests keep coming, table backs up
      if (n == 300) long_hold_pending = 1'b1;
      // sender goes quiet until every result is back
      if (n == 700) wait_for_results();
      if (n == RANDOM_ITEMS - CALM_ITEMS) begin
        tx_calm = 1'b1;
        rx_calm = 1'b1;
      end
      if ($urandom_range(0, 19) == 0) name_pool[$urandom_range(0, POOL_SIZE - 1)] = fresh_pool_key();

      pick       = $urandom_range(0, 99);
      slot_field = 4'($urandom_range(0, 15));
      if (pick < 45) begin
        send_request(ACT_LOOKUP, slot_field, name_pool[$urandom_range(0, pool_span)]);
      end else if (pick < 60) begin
        send_request(ACT_CLOSE, slot_field, name_pool[$urandom_range(0, pool_span)]);
      end else if (pick < 75) begin
        send_request(ACT_TOUCH, slot_field, random_key());
      end else if (pick < 85) begin
        // blank names line up with closed slots and build duplicates
        send_request((pick < 80) ? ACT_LOOKUP : ACT_CLOSE, slot_field,
                     make_key(8'($urandom_range(0, 16)), BLANK_FRONT, BLANK_BACK));
      end else if (pick < 90) begin
        send_request(ACT_UNDEFINED, slot_field, random_key());
      end else begin
        // noise: any action, any key
        send_request(2'($urandom_range(0, 3)), slot_field, random_key());
      end
    end

    // drain, let the pipeline settle, then check for leftovers
    wait_for_results();
    repeat (4) @(posedge clk);
    drain_done = 1'b1;
    repeat (2) @(posedge clk);

    $display("covered %0d lookups, %0d touches, %0d closes and %0d undefined requests",
             sent_by_action[ACT_LOOKUP], sent_by_action[ACT_TOUCH],
             sent_by_action[ACT_CLOSE], sent_by_action[ACT_UNDEFINED]);
    $display("%0d results were hits; one %0d-cycle result hold-off and one full drain pause",
             hit_count, LONG_HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
src/lht_pkg.sv
src/lht_if.sv
src/lht_cell.sv
src/lru_handle_table.sv
test/lht_checker.sv
test/lru_handle_table_tb.sv
